### sv/point_to_primitive_sq_distance_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef POINT_TO_PRIMITIVE_SQ_DISTANCE_UNIT_ASSERT_SVH
`define POINT_TO_PRIMITIVE_SQ_DISTANCE_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PTP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define PTP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### sv/ptp_pkg.sv
package ptp_pkg;

	typedef enum logic [1:0] {
		KIND_SPHERE  = 2'd0,
		KIND_BOX     = 2'd1,
		KIND_CAPSULE = 2'd2,
		KIND_NONE    = 2'd3
	} kind_e;

	typedef enum logic [2:0] {
		REG_SHAPE_KIND = 3'd0,
		REG_ORIGIN     = 3'd1,
		REG_AXIS_X     = 3'd2,
		REG_AXIS_Y     = 3'd3,
		REG_AXIS_Z     = 3'd4,
		REG_HALF_EXT   = 3'd5,
		REG_RADIUS     = 3'd6,
		REG_HALF_INNER = 3'd7
	} reg_idx_e;

	typedef logic [30:0]        mag_t;
	typedef logic signed [31:0] diff_t;
	typedef logic [61:0]        sum_t;

	localparam mag_t        MAG_SAT    = 31'h4000_0000;
	localparam logic [63:0] OUT_MAX    = 64'h0000_000F_FFFF_FFFF;
	localparam int          SQRT_STEPS = 31;
	// front 3 + shape 3 + root steps + post 3
	localparam int          LATENCY    = 6 + SQRT_STEPS + 3;

	typedef struct packed {
		kind_e       kind;
		logic [47:0] origin;
		logic [47:0] axis_x;
		logic [47:0] axis_y;
		logic [47:0] axis_z;
		logic [47:0] half_ext;
		logic [14:0] radius;
		logic [14:0] half_inner;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		kind_e      kind;
		mag_t [2:0] a;
		mag_t [2:0] dmag;
	} proj_t;

	typedef struct packed {
		logic  valid;
		kind_e kind;
		sum_t  x;
	} sumtok_t;

	typedef struct packed {
		logic  valid;
		kind_e kind;
		sum_t  x;
		sum_t  res;
	} root_t;

endpackage

### sv/ptp_front.sv
module ptp_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [COORD_BITS-1:0]  vertex_x,
	input  logic signed [COORD_BITS-1:0]  vertex_y,
	input  logic signed [COORD_BITS-1:0]  vertex_z,
	input  ptp_pkg::cfg_t                 cfg,
	output ptp_pkg::proj_t                out
);
	import ptp_pkg::*;

	logic signed [33:0] v_ext [3];
	logic signed [33:0] o_ext [3];
	logic signed [33:0] diff  [3];
	diff_t              d_c   [3];

	diff_t d_s1 [3];
	logic  vld_s1;
	kind_e kind_s1;

	logic signed [47:0] prod_c  [3][3];
	mag_t               dmag_c  [3];
	logic signed [47:0] prod_s2 [3][3];
	mag_t               dmag_s2 [3];
	logic               vld_s2;
	kind_e              kind_s2;

	logic signed [49:0] p_c  [3];
	logic [49:0]        pm_c [3];
	logic [49:0]        r_c  [3];
	mag_t               a_c  [3];
	mag_t               a_s3    [3];
	mag_t               dmag_s3 [3];
	logic               vld_s3;
	kind_e              kind_s3;

	logic [47:0] axes [3];

	assign axes[0] = cfg.axis_x;
	assign axes[1] = cfg.axis_y;
	assign axes[2] = cfg.axis_z;

	assign v_ext[0] = 34'(vertex_x);
	assign v_ext[1] = 34'(vertex_y);
	assign v_ext[2] = 34'(vertex_z);

	// offset from the origin, clamped to +/- 2^30
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o_ext[i] = 34'(signed'(cfg.origin[16*i +: 16]));
			diff[i]  = v_ext[i] - o_ext[i];
			if (diff[i] > 34'sd1073741824)
				d_c[i] = 32'sd1073741824;
			else if (diff[i] < -34'sd1073741824)
				d_c[i] = -32'sd1073741824;
			else
				d_c[i] = diff[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++)
				prod_c[k][j] = 48'(d_s1[j]) * 48'(signed'(axes[k][16*j +: 16]));
			dmag_c[k] = d_s1[k] < 0 ? mag_t'(-d_s1[k]) : mag_t'(d_s1[k]);
		end
	end

	// project: round the Q1.14 product back to length units, clamp
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_c[k]  = 50'(prod_s2[k][0]) + 50'(prod_s2[k][1]) + 50'(prod_s2[k][2]);
			pm_c[k] = p_c[k] < 0 ? 50'(-p_c[k]) : 50'(p_c[k]);
			r_c[k]  = (pm_c[k] + 50'd8192) >> 14;
			a_c[k]  = r_c[k] > 50'(MAG_SAT) ? MAG_SAT : r_c[k][30:0];
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= cfg.kind;
		kind_s2 <= kind_s1;
		kind_s3 <= kind_s2;
		for (int i = 0; i < 3; i++) begin
			d_s1[i]    <= d_c[i];
			dmag_s2[i] <= dmag_c[i];
			dmag_s3[i] <= dmag_s2[i];
			a_s3[i]    <= a_c[i];
			for (int j = 0; j < 3; j++)
				prod_s2[i][j] <= prod_c[i][j];
		end
	end

	always_comb begin
		out.valid = vld_s3;
		out.kind  = kind_s3;
		for (int i = 0; i < 3; i++) begin
			out.a[i]    = a_s3[i];
			out.dmag[i] = dmag_s3[i];
		end
	end

endmodule

### sv/ptp_shape.sv
module ptp_shape (
	input  logic              clk,
	input  logic              arst_n,
	input  ptp_pkg::proj_t    in,
	input  ptp_pkg::cfg_t     cfg,
	output ptp_pkg::sumtok_t  out
);
	import ptp_pkg::*;

	mag_t h [3];
	mag_t hd [3];
	mag_t od [3];
	mag_t hmin;
	mag_t hi;
	mag_t e;
	logic in_box;
	mag_t q_c [3];

	mag_t  q_s4 [3];
	logic  vld_s4;
	kind_e kind_s4;
	sum_t  sq_s5 [3];
	logic  vld_s5;
	kind_e kind_s5;
	sum_t  x_s6;
	logic  vld_s6;
	kind_e kind_s6;

	always_comb begin
		in_box = 1'b1;
		for (int i = 0; i < 3; i++) begin
			h[i]  = mag_t'(cfg.half_ext[16*i +: 16]);
			hd[i] = h[i] - in.a[i];
			od[i] = in.a[i] > h[i] ? in.a[i] - h[i] : '0;
			if (!(in.a[i] < h[i]))
				in_box = 1'b0;
		end
		hmin = hd[0];
		if (hd[1] < hmin)
			hmin = hd[1];
		if (hd[2] < hmin)
			hmin = hd[2];
		hi = mag_t'(cfg.half_inner);
		e  = in.a[0] > hi ? in.a[0] - hi : '0;

		// pick the three terms whose squares get summed
		case (in.kind)
			KIND_SPHERE: begin
				for (int i = 0; i < 3; i++)
					q_c[i] = in.dmag[i];
			end
			KIND_BOX: begin
				if (in_box) begin
					q_c[0] = hmin;
					q_c[1] = '0;
					q_c[2] = '0;
				end else begin
					for (int i = 0; i < 3; i++)
						q_c[i] = od[i];
				end
			end
			KIND_CAPSULE: begin
				q_c[0] = e;
				q_c[1] = in.a[1];
				q_c[2] = in.a[2];
			end
			default: begin
				for (int i = 0; i < 3; i++)
					q_c[i] = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= in.valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		kind_s4 <= in.kind;
		kind_s5 <= kind_s4;
		kind_s6 <= kind_s5;
		for (int i = 0; i < 3; i++) begin
			q_s4[i]  <= q_c[i];
			sq_s5[i] <= sum_t'(q_s4[i]) * sum_t'(q_s4[i]);
		end
		x_s6 <= sq_s5[0] + sq_s5[1] + sq_s5[2];
	end

	assign out.valid = vld_s6;
	assign out.kind  = kind_s6;
	assign out.x     = x_s6;

endmodule

### sv/ptp_sqrt.sv
module ptp_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  ptp_pkg::sumtok_t  in,
	output ptp_pkg::root_t    out
);
	import ptp_pkg::*;

	logic  vld_s  [SQRT_STEPS+1];
	kind_e kind_s [SQRT_STEPS+1];
	sum_t  x_s    [SQRT_STEPS+1];
	sum_t  res_s  [SQRT_STEPS+1];

	assign vld_s[0]  = in.valid;
	assign kind_s[0] = in.kind;
	assign x_s[0]    = in.x;
	assign res_s[0]  = '0;

	// one result bit per stage; box items ride through untouched
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam sum_t BIT = sum_t'(1) << (2 * (SQRT_STEPS - 1 - k));
		sum_t trial;
		sum_t x_nx;
		sum_t res_nx;
		logic take_root;

		always_comb begin
			take_root = kind_s[k] == KIND_SPHERE || kind_s[k] == KIND_CAPSULE;
			trial     = res_s[k] + BIT;
			x_nx      = x_s[k];
			res_nx    = res_s[k];
			if (take_root) begin
				if (x_s[k] >= trial) begin
					x_nx   = x_s[k] - trial;
					res_nx = (res_s[k] >> 1) + BIT;
				end else begin
					res_nx = res_s[k] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vld_s[k];
		end

		always_ff @(posedge clk) begin
			kind_s[k+1] <= kind_s[k];
			x_s[k+1]    <= x_nx;
			res_s[k+1]  <= res_nx;
		end
	end

	assign out.valid = vld_s[SQRT_STEPS];
	assign out.kind  = kind_s[SQRT_STEPS];
	assign out.x     = x_s[SQRT_STEPS];
	assign out.res   = res_s[SQRT_STEPS];

endmodule

### sv/ptp_post.sv
module ptp_post #(
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ptp_pkg::root_t  in,
	input  logic [14:0]     radius,
	output logic            done,
	output logic [35:0]     sq_distance
);
	import ptp_pkg::*;

	localparam int          TF  = 2 * COORD_FRAC_BITS;
	localparam int          RSH = TF >= 16 ? TF - 16 : 0;
	localparam int          LSH = TF >= 16 ? 0 : 16 - TF;
	localparam logic [63:0] RND = (64'd1 << RSH) >> 1;

	logic is_root;
	mag_t root;
	mag_t rad;
	mag_t m;

	sum_t  val_s1;
	logic  root_s1;
	logic  vld_s1;
	kind_e kind_s1;
	sum_t  sq_s2;
	logic  vld_s2;
	kind_e kind_s2;
	logic [63:0] w;
	logic [35:0] res_c;
	logic [35:0] sq_s3;
	logic        vld_s3;

	always_comb begin
		is_root = in.kind == KIND_SPHERE || in.kind == KIND_CAPSULE;
		root    = in.res[30:0];
		rad     = mag_t'(radius);
		m       = root >= rad ? root - rad : rad - root;
	end

	// move to 16 fraction bits: round on a right shift, clamp to OUT_MAX; kind NONE gives zero
	always_comb begin
		if (TF >= 16)
			w = (64'(sq_s2) + RND) >> RSH;
		else if (64'(sq_s2) > (OUT_MAX >> LSH))
			w = OUT_MAX;
		else
			w = 64'(sq_s2) << LSH;
		if (kind_s2 == KIND_NONE)
			res_c = '0;
		else if (w > OUT_MAX)
			res_c = OUT_MAX[35:0];
		else
			res_c = w[35:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		val_s1  <= is_root ? sum_t'(m) : in.x;
		root_s1 <= is_root;
		kind_s1 <= in.kind;
		sq_s2   <= root_s1 ? sum_t'(val_s1[30:0]) * sum_t'(val_s1[30:0]) : val_s1;
		kind_s2 <= kind_s1;
		sq_s3   <= res_c;
	end

	assign done        = vld_s3;
	assign sq_distance = sq_s3;

endmodule

### sv/point_to_primitive_sq_distance_unit.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+------------------------------------------
// vertex    | start, busy             | vertex_x, vertex_y, vertex_z
// config    | cfg_valid, cfg_ready    | cfg_index, cfg_data
// result    | done (one-cycle strobe) | sq_distance
//
// One vertex is taken every clock; busy stays low and cfg_ready stays high.
// A request passes through the offset, projection and squaring stages, then the square root
// stages at one result bit per stage, then the finishing stages.
// Reset clears the valid bits and the configuration; nothing needs clearing after it.
// The receiver cannot stall, so the pipeline advances every cycle.
module point_to_primitive_sq_distance_unit #(
	parameter int COORD_BITS      = 16,
	parameter int COORD_FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic signed [COORD_BITS-1:0] vertex_z,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [47:0]                  cfg_data,
	output logic                         done,
	output logic [35:0]                  sq_distance
);
	import ptp_pkg::*;

	cfg_t    cfg_q;
	proj_t   proj;
	sumtok_t sums;
	root_t   roots;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_e'(cfg_index))
				REG_SHAPE_KIND: cfg_q.kind       <= kind_e'(cfg_data[1:0]);
				REG_ORIGIN:     cfg_q.origin     <= cfg_data;
				REG_AXIS_X:     cfg_q.axis_x     <= cfg_data;
				REG_AXIS_Y:     cfg_q.axis_y     <= cfg_data;
				REG_AXIS_Z:     cfg_q.axis_z     <= cfg_data;
				REG_HALF_EXT:   cfg_q.half_ext   <= cfg_data;
				REG_RADIUS:     cfg_q.radius     <= cfg_data[14:0];
				REG_HALF_INNER: cfg_q.half_inner <= cfg_data[14:0];
			endcase
		end
	end

	ptp_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.vertex_x (vertex_x),
		.vertex_y (vertex_y),
		.vertex_z (vertex_z),
		.cfg      (cfg_q),
		.out      (proj)
	);

	ptp_shape u_shape (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (proj),
		.cfg    (cfg_q),
		.out    (sums)
	);

	ptp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (sums),
		.out    (roots)
	);

	ptp_post #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_post (
		.clk         (clk),
		.arst_n      (arst_n),
		.in          (roots),
		.radius      (cfg_q.radius),
		.done        (done),
		.sq_distance (sq_distance)
	);

endmodule

### sv/ptp_checker.sv
`include "point_to_primitive_sq_distance_unit_assert.svh"

module ptp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic done
);
	import ptp_pkg::*;

	localparam int CW = $clog2(LATENCY + 1);

	logic [CW-1:0] cycles_q;

	// count cycles since reset, hold at the pipeline latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cycles_q <= '0;
		else if (cycles_q != CW'(LATENCY))
			cycles_q <= cycles_q + 1'b1;
	end

	`PTP_ASSERT_IMPL(a_latency, cycles_q == CW'(LATENCY), done == $past(start && !busy, LATENCY), "result strobe does not match request latency")
	`PTP_ASSERT_NEVER(a_quiet_after_reset, cycles_q != CW'(LATENCY) && done, "result strobe before pipeline can be full")
	`PTP_ASSERT_NEVER(a_never_busy, busy, "busy raised on a stall-free pipeline")
	`PTP_ASSERT_IMPL(a_cfg_taken, cfg_valid, cfg_ready, "configuration write held off")

endmodule

bind point_to_primitive_sq_distance_unit ptp_checker u_ptp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.done      (done)
);
